// ===== src/fwpr_pkg.sv =====
package fwpr_pkg;

   // Queue geometry. The ring wraps by truncation, so the depth is a power of two.
   localparam int DEPTH  = 16;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;
   localparam int CMD_W  = 2;
   localparam int K_W    = 5;
   localparam int ST_W   = 2;

   // Command codes carried in the cmd field of an input item.
   typedef enum logic [CMD_W-1:0] {
      CMD_ENQ = 2'd0,
      CMD_DEQ = 2'd1,
      CMD_REV = 2'd2
   } cmd_type;

   // Status codes returned with every result item.
   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_KBIG  = 2'd3
   } status_type;

   // One input item.
   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic signed [WORD_W-1:0] value;
      logic [K_W-1:0]           count_k;
   } req_type;

   // One result item.
   typedef struct packed {
      logic signed [WORD_W-1:0] data;
      logic [ST_W-1:0]          status;
      logic [CNT_W-1:0]         occupancy;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       latch_req;
      logic       set_status;
      status_type status_code;
      logic       push;
      logic       pop;
      logic       rd_head;
      logic       rd_a;
      logic       rd_b;
      logic       save_a;
      logic       wr_a;
      logic       wr_b;
      logic       clr_idx;
      logic       inc_idx;
      logic       load_rsp;
   } ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             full;
      logic             empty;
      logic             kbig;
      logic             no_swap;
      logic             last_swap;
      logic             rsp_free;
   } dp_status_type;

endpackage

// ===== src/fifo_with_prefix_reverse.sv =====
// Bounded queue of 16 signed 32-bit words with three commands: enqueue,
// dequeue and reversal of the oldest k entries in place. Every item gives one
// result with the dequeued word (zero unless a dequeue succeeds), a status
// code and the occupancy after the command. Items are handled one at a time
// by a controller over a single storage array that does one read and one
// write per cycle. A reverse swaps floor(k / 2) pairs; each pair is swapped by
// reading both entries, then writing both back. A finished result waits in
// an output register, and the next item is accepted while it waits.
module fifo_with_prefix_reverse (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fwpr_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fwpr_pkg::rsp_type rsp_item
);

   fwpr_pkg::ctrl_type      ctrl;
   fwpr_pkg::dp_status_type dp_status;

   // Command sequencer.
   fwpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .ctrl      (ctrl)
   );

   // Storage, pointers and output register.
   fwpr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .ctrl      (ctrl),
      .dp_status (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // The storage array is never written while a new item can be taken.
   a_no_write_when_ready: assert property (@(posedge clock) disable iff (reset)
      (ctrl.push || ctrl.wr_a || ctrl.wr_b) |-> !req_ready)
      else $error("storage written while the block accepts items");

   // A refused command returns a zero word.
   a_zero_data_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status != fwpr_pkg::ST_OK)) |-> (rsp_item.data == '0))
      else $error("nonzero data with an error status");

   // A full report comes with a full queue, an empty report with an empty one.
   a_full_occupancy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status == fwpr_pkg::ST_FULL))
      |-> (rsp_item.occupancy == fwpr_pkg::CNT_W'(fwpr_pkg::DEPTH)))
      else $error("full status with a queue that is not full");

   a_empty_occupancy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status == fwpr_pkg::ST_EMPTY)) |-> (rsp_item.occupancy == '0))
      else $error("empty status with a queue that is not empty");

endmodule

// ===== src/fwpr_datapath.sv =====
module fwpr_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  fwpr_pkg::req_type      req_item,
   input  fwpr_pkg::ctrl_type     ctrl,
   output fwpr_pkg::dp_status_type dp_status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output fwpr_pkg::rsp_type      rsp_item
);

   // Ring storage, one write and one registered read per cycle.
   logic signed [fwpr_pkg::WORD_W-1:0] mem [fwpr_pkg::DEPTH];

   logic [fwpr_pkg::ADDR_W-1:0]        head_ff, head_in;
   logic [fwpr_pkg::CNT_W-1:0]         count_ff, count_in;
   fwpr_pkg::req_type                  req_ff;
   logic [fwpr_pkg::ADDR_W-1:0]        idx_ff;
   logic signed [fwpr_pkg::WORD_W-1:0] rd_data_ff;
   logic signed [fwpr_pkg::WORD_W-1:0] ta_ff;
   logic [fwpr_pkg::ST_W-1:0]          status_ff;
   logic                               rsp_valid_ff;
   fwpr_pkg::rsp_type                  rsp_ff;

   logic [fwpr_pkg::ADDR_W-1:0]        tail_addr;
   logic [fwpr_pkg::ADDR_W-1:0]        a_addr;
   logic [fwpr_pkg::ADDR_W-1:0]        b_addr;
   logic [fwpr_pkg::CNT_W-1:0]         k_cnt;
   logic [fwpr_pkg::CNT_W-1:0]         half_k;
   logic [fwpr_pkg::CNT_W-1:0]         idx_cnt;
   logic [fwpr_pkg::CNT_W-1:0]         b_off;
   logic [fwpr_pkg::ADDR_W-1:0]        rd_addr;
   logic                               rd_en;
   logic [fwpr_pkg::ADDR_W-1:0]        wr_addr;
   logic signed [fwpr_pkg::WORD_W-1:0] wr_data;
   logic                               wr_en;
   logic                               deq_ok;

   // Ring addresses of the tail and of the two entries of the current swap.
   always_comb begin
      k_cnt     = fwpr_pkg::CNT_W'(req_ff.count_k);
      half_k    = k_cnt >> 1;
      idx_cnt   = fwpr_pkg::CNT_W'(idx_ff);
      b_off     = k_cnt - fwpr_pkg::CNT_W'(1) - idx_cnt;
      tail_addr = head_ff + count_ff[fwpr_pkg::ADDR_W-1:0];
      a_addr    = head_ff + idx_ff;
      b_addr    = head_ff + b_off[fwpr_pkg::ADDR_W-1:0];
   end

   // Status toward the controller.
   always_comb begin
      dp_status.cmd       = req_ff.cmd;
      dp_status.full      = (count_ff == fwpr_pkg::CNT_W'(fwpr_pkg::DEPTH));
      dp_status.empty     = (count_ff == '0);
      dp_status.kbig      = (k_cnt > count_ff);
      dp_status.no_swap   = (half_k == '0);
      dp_status.last_swap = ((idx_cnt + fwpr_pkg::CNT_W'(1)) == half_k);
      dp_status.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   // Memory port selection.
   always_comb begin
      rd_en   = ctrl.rd_head || ctrl.rd_a || ctrl.rd_b;
      rd_addr = head_ff;
      if (ctrl.rd_a) begin
         rd_addr = a_addr;
      end else if (ctrl.rd_b) begin
         rd_addr = b_addr;
      end
      wr_en   = ctrl.push || ctrl.wr_a || ctrl.wr_b;
      wr_addr = tail_addr;
      wr_data = req_ff.value;
      if (ctrl.wr_a) begin
         wr_addr = a_addr;
         wr_data = rd_data_ff;
      end else if (ctrl.wr_b) begin
         wr_addr = b_addr;
         wr_data = ta_ff;
      end
   end

   // Storage array.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Ring pointer and occupancy.
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + fwpr_pkg::CNT_W'(1);
      end else if (ctrl.pop) begin
         head_in  = head_ff + fwpr_pkg::ADDR_W'(1);
         count_in = count_ff - fwpr_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Working registers of one item.
   always_ff @(posedge clock) begin
      if (ctrl.latch_req) begin
         req_ff <= req_item;
      end
      if (ctrl.set_status) begin
         status_ff <= ctrl.status_code;
      end
      if (ctrl.save_a) begin
         ta_ff <= rd_data_ff;
      end
      if (ctrl.clr_idx) begin
         idx_ff <= '0;
      end else if (ctrl.inc_idx) begin
         idx_ff <= idx_ff + fwpr_pkg::ADDR_W'(1);
      end
   end

   // Output register; it holds a result until the consumer takes it.
   assign deq_ok = (req_ff.cmd == fwpr_pkg::CMD_DEQ) && (status_ff == fwpr_pkg::ST_OK);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_rsp) begin
         rsp_ff.data      <= deq_ok ? rd_data_ff : '0;
         rsp_ff.status    <= status_ff;
         rsp_ff.occupancy <= count_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== src/fwpr_ctrl.sv =====
module fwpr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  fwpr_pkg::dp_status_type dp_status,
   output fwpr_pkg::ctrl_type      ctrl
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_READ_A,
      S_READ_B,
      S_WRITE_A,
      S_WRITE_B,
      S_RESP
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands for the datapath.
   always_comb begin
      state_in         = state_ff;
      ctrl             = '0;
      ctrl.status_code = fwpr_pkg::ST_OK;
      req_ready        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.latch_req = 1'b1;
               state_in       = S_DECODE;
            end
         end
         S_DECODE: begin
            ctrl.set_status = 1'b1;
            state_in        = S_RESP;
            case (dp_status.cmd)
               fwpr_pkg::CMD_ENQ: begin
                  if (dp_status.full) begin
                     ctrl.status_code = fwpr_pkg::ST_FULL;
                  end else begin
                     ctrl.push = 1'b1;
                  end
               end
               fwpr_pkg::CMD_DEQ: begin
                  if (dp_status.empty) begin
                     ctrl.status_code = fwpr_pkg::ST_EMPTY;
                  end else begin
                     ctrl.rd_head = 1'b1;
                     ctrl.pop     = 1'b1;
                  end
               end
               fwpr_pkg::CMD_REV: begin
                  if (dp_status.kbig) begin
                     ctrl.status_code = fwpr_pkg::ST_KBIG;
                  end else if (!dp_status.no_swap) begin
                     ctrl.clr_idx = 1'b1;
                     state_in     = S_READ_A;
                  end
               end
               default: begin
               end
            endcase
         end
         S_READ_A: begin
            ctrl.rd_a = 1'b1;
            state_in  = S_READ_B;
         end
         S_READ_B: begin
            ctrl.rd_b   = 1'b1;
            ctrl.save_a = 1'b1;
            state_in    = S_WRITE_A;
         end
         S_WRITE_A: begin
            ctrl.wr_a = 1'b1;
            state_in  = S_WRITE_B;
         end
         S_WRITE_B: begin
            ctrl.wr_b    = 1'b1;
            ctrl.inc_idx = 1'b1;
            state_in     = dp_status.last_swap ? S_RESP : S_READ_A;
         end
         S_RESP: begin
            if (dp_status.rsp_free) begin
               ctrl.load_rsp = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
